FILE: rtl/sl2re_pkg.sv
// ----------------------------------------------------------------------------
// sl2re_pkg
// Shared types, character codes and the regex-special test for the SQL LIKE
// to POSIX regex translator.
// ----------------------------------------------------------------------------
`default_nettype none

package sl2re_pkg;

  localparam logic [7:0] ESC_RESET = 8'h5C;  // backslash

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PCT    = 8'h25;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ESC_END = 2'd1,
    ST_BAD_ESC = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       pattern_end;
    status_t    status;
  } res_t;

  // up to two results produced by one pattern byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic logic is_special(input logic [7:0] c);
    logic hit;
    hit = c inside {8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7C, 8'h5E, 8'h2D,
                    8'h2B, 8'h2A, 8'h3F, 8'h7B, 8'h7D, 8'h24, 8'h5C};
    return hit;
  endfunction

  function automatic res_t mk_char(input logic [7:0] c);
    res_t r;
    r             = '0;
    r.out_char    = c;
    r.char_valid  = 1'b1;
    r.status      = ST_OK;
    return r;
  endfunction

  function automatic res_t mk_status(input status_t s);
    res_t r;
    r        = '0;
    r.status = s;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sl2re_if.sv
// ----------------------------------------------------------------------------
// sl2re channel interfaces
// Valid/ready channels for pattern bytes, regex results and the escape byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface sl2re_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_char;
  logic       pattern_last;

  modport source (output valid, output pattern_char, output pattern_last, input ready);
  modport sink   (input valid, input pattern_char, input pattern_last, output ready);
endinterface

interface sl2re_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       pattern_end;
  logic [1:0] status;

  modport source (output valid, output out_char, output char_valid, output run_last,
                  output pattern_end, output status, input ready);
  modport sink   (input valid, input out_char, input char_valid, input run_last,
                  input pattern_end, input status, output ready);
endinterface

interface sl2re_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] escape_byte;

  modport source (output valid, output escape_byte, input ready);
  modport sink   (input valid, input escape_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/sl2re_decode.sv
// ----------------------------------------------------------------------------
// sl2re_decode
// Translates one pattern byte into up to two regex results and keeps the
// escape-pending and error state of the current pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module sl2re_decode (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    accept,
  input  wire [7:0]              pattern_char,
  input  wire                    pattern_last,
  input  wire [7:0]              escape_byte,
  output sl2re_pkg::res_pair_t   pair
);
  import sl2re_pkg::*;

  logic    pend_r, pend_nxt;
  status_t err_r, err_nxt;
  logic    special;

  always_comb begin
    special  = is_special(pattern_char);
    pair     = '0;
    pend_nxt = pend_r;
    err_nxt  = err_r;

    if (err_r != ST_OK) begin
      if (pattern_last) begin
        pair.cnt = 2'd1;
        pair.r0  = mk_status(err_r);
      end
    end else if (pend_r) begin
      pend_nxt = 1'b0;
      pair.cnt = 2'd1;
      if (pattern_char == CH_UNDER || pattern_char == CH_PCT ||
          pattern_char == escape_byte) begin
        pair.r0 = mk_char(pattern_char);
      end else begin
        err_nxt = ST_BAD_ESC;
        pair.r0 = mk_status(ST_BAD_ESC);
      end
    end else if (pattern_char == escape_byte) begin
      if (pattern_last) begin
        err_nxt  = ST_ESC_END;
        pair.cnt = 2'd1;
        pair.r0  = mk_status(ST_ESC_END);
      end else begin
        pend_nxt = 1'b1;
        // a special escape byte still carries its own backslash prefix
        if (special) begin
          pair.cnt = 2'd1;
          pair.r0  = mk_char(CH_BSLASH);
        end
      end
    end else if (special) begin
      pair.cnt = 2'd2;
      pair.r0  = mk_char(CH_BSLASH);
      pair.r1  = mk_char(pattern_char);
    end else if (pattern_char == CH_UNDER) begin
      pair.cnt = 2'd1;
      pair.r0  = mk_char(CH_DOT);
    end else if (pattern_char == CH_PCT) begin
      pair.cnt = 2'd2;
      pair.r0  = mk_char(CH_DOT);
      pair.r1  = mk_char(CH_STAR);
    end else begin
      pair.cnt = 2'd1;
      pair.r0  = mk_char(pattern_char);
    end

    // tag the last result of this byte
    if (pair.cnt == 2'd1) begin
      pair.r0.run_last    = 1'b1;
      pair.r0.pattern_end = pattern_last;
    end else if (pair.cnt == 2'd2) begin
      pair.r1.run_last    = 1'b1;
      pair.r1.pattern_end = pattern_last;
    end

    if (pattern_last) begin
      pend_nxt = 1'b0;
      err_nxt  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      err_r  <= ST_OK;
    end else if (accept) begin
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sl2re_outbuf.sv
// ----------------------------------------------------------------------------
// sl2re_outbuf
// Holds the results of one byte and feeds them through an output register,
// one beat per cycle unless the result sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sl2re_outbuf (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire sl2re_pkg::res_pair_t pair,
  output logic                   can_push,
  sl2re_out_if.source            out_ch
);
  import sl2re_pkg::*;

  res_t       slot0_r, slot1_r;
  logic [1:0] cnt_r;
  res_t       out_r;
  logic       ov_r;
  logic       move;

  assign move     = (cnt_r != 2'd0) && (!ov_r || out_ch.ready);
  // the held results must be gone (or leaving) before a new byte lands
  assign can_push = (cnt_r == 2'd0) || (cnt_r == 2'd1 && move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      if (push) begin
        cnt_r <= pair.cnt;
      end else if (move) begin
        cnt_r <= cnt_r - 2'd1;
      end
      if (move) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0_r <= pair.r0;
      slot1_r <= pair.r1;
    end else if (move) begin
      slot0_r <= slot1_r;
    end
    if (move) begin
      out_r <= slot0_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_char    = out_r.out_char;
  assign out_ch.char_valid  = out_r.char_valid;
  assign out_ch.run_last    = out_r.run_last;
  assign out_ch.pattern_end = out_r.pattern_end;
  assign out_ch.status      = out_r.status;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && move)))
    else $error("new byte overwrote pending results");

  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !slot0_r.run_last && slot1_r.run_last)
    else $error("run_last misplaced in held pair");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0 && !move) |=> cnt_r == $past(cnt_r))
    else $error("held results changed while blocked");

endmodule

`default_nettype wire

FILE: rtl/sql_like_to_posix_regex_unit.sv
// ----------------------------------------------------------------------------
// sql_like_to_posix_regex_unit
// SQL LIKE pattern to POSIX regex translator, one pattern byte per beat.
// ----------------------------------------------------------------------------
// Each pattern byte is decoded in the cycle it is accepted and its results
// are handed to a one-beat output register. Bytes that give two results
// (a regex special with its backslash prefix, or percent as dot-star) hold
// off the next byte longer than bytes that give one result or none, since
// the result channel moves one regex byte per beat. Results pass through
// the holding slots before the output register. The escape byte resets to
// backslash and should be written only while no pattern is in flight.
`default_nettype none

module sql_like_to_posix_regex_unit (
  input  wire           clk,
  input  wire           rst_n,
  sl2re_in_if.sink      in_ch,
  sl2re_cfg_if.sink     cfg_ch,
  sl2re_out_if.source   out_ch
);
  import sl2re_pkg::*;

  logic [7:0] esc_r;
  res_pair_t  pair;
  logic       can_push;
  logic       accept;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= ESC_RESET;
    end else if (cfg_ch.valid) begin
      esc_r <= cfg_ch.escape_byte;
    end
  end

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  sl2re_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pattern_char (in_ch.pattern_char),
    .pattern_last (in_ch.pattern_last),
    .escape_byte  (esc_r),
    .pair         (pair)
  );

  sl2re_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .pair     (pair),
    .can_push (can_push),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SQL LIKE to POSIX regex translator. Directed
// patterns cover literals, wildcards, escapes and both error cases; random
// patterns run under several escape bytes with bursty input and a stalling
// result sink. Every result beat is checked field by field against a
// predictor that tracks escape and error state per pattern.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sl2re_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;

  localparam logic [7:0] REGEX_SPECIALS [14] = '{
    8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7C, 8'h5E, 8'h2D,
    8'h2B, 8'h2A, 8'h3F, 8'h7B, 8'h7D, 8'h24, 8'h5C
  };

  typedef enum int {SINK_OPEN, SINK_HALF, SINK_MOSTLY, SINK_TOGGLE} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  sl2re_in_if  in_bus ();
  sl2re_out_if out_bus ();
  sl2re_cfg_if cfg_bus ();

  sql_like_to_posix_regex_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .cfg_ch (cfg_bus),
    .out_ch (out_bus)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [7:0] esc_byte;
  logic       esc_pending;
  status_t    err_state;
  res_t       regex_q [$];

  int   errors      = 0;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  int   gap_max     = 3;
  logic hold_req    = 1'b0;

  function automatic logic needs_prefix(input logic [7:0] c);
    foreach (REGEX_SPECIALS[i]) begin
      if (REGEX_SPECIALS[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t make_beat(input logic [7:0] c, input logic valid,
                                     input status_t st);
    res_t b;
    b            = '0;
    b.out_char   = valid ? c : 8'h00;
    b.char_valid = valid;
    b.status     = st;
    return b;
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic last);
    res_t beats [2];
    int   n;
    n = 0;
    if (err_state != ST_OK) begin
      // failed pattern stays silent until its final byte
      if (last) begin
        beats[n] = make_beat(8'h00, 1'b0, err_state);
        n++;
      end
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (c == CH_UNDER || c == CH_PCT || c == esc_byte) begin
        beats[n] = make_beat(c, 1'b1, ST_OK);
        n++;
      end else begin
        err_state = ST_BAD_ESC;
        beats[n]  = make_beat(8'h00, 1'b0, ST_BAD_ESC);
        n++;
      end
    end else if (c == esc_byte) begin
      if (last) begin
        err_state = ST_ESC_END;
        beats[n]  = make_beat(8'h00, 1'b0, ST_ESC_END);
        n++;
      end else begin
        if (needs_prefix(c)) begin
          beats[n] = make_beat(CH_BSLASH, 1'b1, ST_OK);
          n++;
        end
        esc_pending = 1'b1;
      end
    end else begin
      if (needs_prefix(c)) begin
        beats[n] = make_beat(CH_BSLASH, 1'b1, ST_OK);
        n++;
      end
      if (c == CH_UNDER) begin
        beats[n] = make_beat(CH_DOT, 1'b1, ST_OK);
        n++;
      end else if (c == CH_PCT) begin
        beats[0] = make_beat(CH_DOT, 1'b1, ST_OK);
        beats[1] = make_beat(CH_STAR, 1'b1, ST_OK);
        n = 2;
      end else begin
        beats[n] = make_beat(c, 1'b1, ST_OK);
        n++;
      end
    end
    if (n > 0) begin
      beats[n-1].run_last    = 1'b1;
      beats[n-1].pattern_end = last;
    end
    if (last) begin
      esc_pending = 1'b0;
      err_state   = ST_OK;
    end
    for (int i = 0; i < n; i++) regex_q.push_back(beats[i]);
  endfunction

  // one pattern byte, then an optional gap once the burst runs out
  task automatic send_byte(input logic [7:0] c, input logic last);
    in_bus.valid        <= 1'b1;
    in_bus.pattern_char <= c;
    in_bus.pattern_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    predict_byte(c, last);
    if (burst_left > 0 || gap_max == 0) begin
      burst_left--;
    end else begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (regex_q.size() != 0) @(posedge clk);
    // a trailing escape byte leaves nothing to wait on, so give it time
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_escape(input logic [7:0] value);
    drain();
    cfg_bus.valid       <= 1'b1;
    cfg_bus.escape_byte <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    esc_byte = value;
  endtask

  // mostly well-formed patterns, some broken escapes and plain noise
  task automatic run_patterns(input int n_items);
    int         sent;
    int         len;
    int         pos;
    int         pick;
    logic [7:0] c;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      pos = 0;
      while (pos < len) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          send_byte(esc_byte, pos == len - 1);
          pos++;
          sent++;
          if (pos < len) begin
            case ($urandom_range(0, 9))
              0, 1, 2: c = CH_UNDER;
              3, 4:    c = CH_PCT;
              5, 6, 7: c = esc_byte;
              default: c = 8'($urandom_range(0, 255));
            endcase
          end else begin
            continue;
          end
        end else if (pick < 40) begin
          c = REGEX_SPECIALS[$urandom_range(0, 13)];
        end else if (pick < 55) begin
          c = $urandom_range(0, 1) ? CH_UNDER : CH_PCT;
        end else if (pick < 75) begin
          c = 8'($urandom_range(8'h61, 8'h7A));
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        send_byte(c, pos == len - 1);
        pos++;
        sent++;
      end
    end
  endtask

  task automatic test_literals_and_wildcards();
    send_byte("a", 1'b0);
    send_byte("[", 1'b0);
    send_byte("]", 1'b0);
    send_byte(CH_UNDER, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_UNDER, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte("$", 1'b1);
  endtask

  task automatic test_escape_errors();
    // escape as the final byte
    send_byte("x", 1'b0);
    send_byte(CH_BSLASH, 1'b1);
    // bad escape mid-pattern, rest of pattern suppressed
    send_byte(CH_BSLASH, 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    // bad escape on the final byte
    send_byte(CH_BSLASH, 1'b0);
    send_byte("z", 1'b1);
  endtask

  task automatic test_escape_setting(input logic [7:0] value, input int n_items);
    set_escape(value);
    case ($urandom_range(0, 3))
      0:       gap_max = 0;
      1:       gap_max = 2;
      2:       gap_max = 6;
      default: gap_max = 16;
    endcase
    run_patterns(n_items);
  endtask

  // sink holds off while bytes keep coming, so the input has to back up
  task automatic test_receiver_hold();
    drain();
    gap_max  = 0;
    hold_req = 1'b1;
    run_patterns(60);
    drain();
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.pattern_char <= 8'h00;
    in_bus.pattern_last <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.escape_byte <= 8'h00;
    esc_byte    = ESC_RESET;
    esc_pending = 1'b0;
    err_state   = ST_OK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_literals_and_wildcards();
    test_escape_errors();
    test_escape_setting(ESC_RESET, 150);
    test_escape_setting(8'h00, 150);
    test_escape_setting(8'hFF, 150);
    test_escape_setting(CH_UNDER, 150);
    test_escape_setting(CH_PCT, 150);
    test_escape_setting("*", 150);
    test_escape_setting("a", 150);
    test_receiver_hold();
    test_escape_setting(8'($urandom_range(0, 255)), 150);
    test_escape_setting(ESC_RESET, 150);

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    mode      = SINK_OPEN;
    mode_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   out_bus.ready <= 1'b1;
          SINK_HALF:   out_bus.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: out_bus.ready <= ($urandom_range(0, 4) != 0);
          default:     out_bus.ready <= ~out_bus.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t exp_beat;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (regex_q.size() == 0) begin
        $error("result beat with nothing expected: out_char %h status %0d",
               out_bus.out_char, out_bus.status);
        errors++;
      end else begin
        exp_beat = regex_q.pop_front();
        if (out_bus.out_char !== exp_beat.out_char) begin
          $error("out_char: expected %h, got %h", exp_beat.out_char, out_bus.out_char);
          errors++;
        end
        if (out_bus.char_valid !== exp_beat.char_valid) begin
          $error("char_valid: expected %b, got %b", exp_beat.char_valid,
                 out_bus.char_valid);
          errors++;
        end
        if (out_bus.run_last !== exp_beat.run_last) begin
          $error("run_last: expected %b, got %b", exp_beat.run_last, out_bus.run_last);
          errors++;
        end
        if (out_bus.pattern_end !== exp_beat.pattern_end) begin
          $error("pattern_end: expected %b, got %b", exp_beat.pattern_end,
                 out_bus.pattern_end);
          errors++;
        end
        if (out_bus.status !== exp_beat.status) begin
          $error("status: expected %0d, got %0d", exp_beat.status, out_bus.status);
          errors++;
        end
      end
    end
  end

  // no handshake on any channel for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
